// ===== src/lz77_pkg.sv =====
// Package for the LZ77 token decoder: history geometry, field widths,
// register map. No dependencies.

package lz77_pkg;

  localparam int HISTORY_DEPTH = 4096;
  localparam int MAX_MATCH     = 63;

  localparam int ADDR_W = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

  // fixed field widths
  localparam int OFF_W  = 13;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;
  localparam int WIN_W  = 13;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_WINDOW = 0;
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4096);

endpackage

// ===== src/lz77_token_decoder.sv =====
// LZ77 token decoder top level: token intake, history RAM, byte output.
// Depends on lz77_pkg.
//
// A copy token's first byte passes the copy state, the registered RAM read and the
// output register; a literal-only or rejected token, its own state and the output
// register. A valid token of length L gives L+1 bytes at one byte per cycle while
// the output is not stalled; the next token is taken once its last byte is registered.
// The history RAM sets the rate: one read and one write per copied byte. Reset clears
// the write pointer and fill count and loads WINDOW_RESET into the window register;
// the history RAM is not cleared and only bytes inside the valid fill are ever read.

module lz77_token_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: match_offset[12:0], match_length[18:13], literal[26:19], zeros above
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lz77_pkg::IN_DATA_W-1:0]     in_tdata,
  // out_tdata: out_byte[7:0]; out_tlast: last; out_tuser: bad_token[0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lz77_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  output logic [0:0]                         out_tuser,
  // APB-style configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [lz77_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [lz77_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [lz77_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import lz77_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_COPY, ST_LIT, ST_ERR} state_t;

  state_t              state_r, state_nxt;
  logic [WIN_W-1:0]    window_r, window_nxt;
  logic [ADDR_W-1:0]   wp_r, wp_nxt;
  logic [ADDR_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LEN_W-1:0]    iss_cnt_r, iss_cnt_nxt;
  logic [LEN_W-1:0]    cons_cnt_r, cons_cnt_nxt;
  logic [BYTE_W-1:0]   lit_r, lit_nxt;
  logic                off1_r, off1_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_bad_r, out_bad_nxt;

  // history memory
  logic [BYTE_W-1:0]   hist_mem [HISTORY_DEPTH];
  logic [BYTE_W-1:0]   ram_q;
  logic                ram_we, ram_re;
  logic [BYTE_W-1:0]   ram_wdata;

  // token fields
  logic [OFF_W-1:0]    tok_off;
  logic [LEN_W-1:0]    tok_len_raw, tok_len;
  logic [BYTE_W-1:0]   tok_lit;

  logic [FILL_W-1:0]   win;
  logic [FILL_W-1:0]   fill_eff;
  logic [FILL_W:0]     fill_inc;
  logic [FILL_W-1:0]   fill_step;
  logic                tok_bad;
  logic [ADDR_W:0]     src_diff;
  logic [ADDR_W-1:0]   src_addr;
  logic                slot_free, consume, issue;
  logic [BYTE_W-1:0]   copy_byte;
  logic                cfg_wr;

  assign tok_off     = in_tdata[OFF_W-1:0];
  assign tok_len_raw = in_tdata[OFF_W+LEN_W-1:OFF_W];
  assign tok_lit     = in_tdata[OFF_W+LEN_W+BYTE_W-1:OFF_W+LEN_W];
  assign tok_len     = (32'(tok_len_raw) > MAX_MATCH) ? LEN_W'(MAX_MATCH) : tok_len_raw;

  // active window, clamped to 1..HISTORY_DEPTH
  always_comb begin
    if (window_r == '0) begin
      win = FILL_W'(1);
    end else if (32'(window_r) > HISTORY_DEPTH) begin
      win = FILL_W'(HISTORY_DEPTH);
    end else begin
      win = FILL_W'(window_r);
    end
  end

  assign fill_eff  = (fill_r < win) ? fill_r : win;
  assign fill_inc  = {1'b0, fill_eff} + (FILL_W+1)'(1);
  assign fill_step = (fill_inc > {1'b0, win}) ? win : fill_inc[FILL_W-1:0];

  assign tok_bad = (tok_len != '0) &&
                   ((tok_off == '0) || (32'(tok_off) > 32'(fill_eff)));

  // copy source: write pointer minus offset, modulo the depth
  assign src_diff = {1'b0, wp_r} - (ADDR_W+1)'(tok_off);
  assign src_addr = src_diff[ADDR_W] ?
                    ADDR_W'(src_diff + (ADDR_W+1)'(HISTORY_DEPTH)) : src_diff[ADDR_W-1:0];

  assign slot_free = !out_valid_r || out_tready;
  assign consume   = (state_r == ST_COPY) && rd_pend_r && slot_free;
  assign issue     = (state_r == ST_COPY) && (iss_cnt_r != len_r) && (!rd_pend_r || consume);

  // offset one repeats the previous byte; RAM read of it would race its write
  assign copy_byte = (off1_r && (cons_cnt_r != '0)) ? out_byte_r : ram_q;

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
    return (a == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : a + ADDR_W'(1);
  endfunction

  always_comb begin
    state_nxt     = state_r;
    window_nxt    = window_r;
    wp_nxt        = wp_r;
    rd_addr_nxt   = rd_addr_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    iss_cnt_nxt   = iss_cnt_r;
    cons_cnt_nxt  = cons_cnt_r;
    lit_nxt       = lit_r;
    off1_nxt      = off1_r;
    rd_pend_nxt   = rd_pend_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wdata     = lit_r;

    if (cfg_wr && (cfg_paddr[2] == 1'(REG_WINDOW))) begin
      window_nxt = cfg_pwdata[WIN_W-1:0];
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          len_nxt      = tok_len;
          lit_nxt      = tok_lit;
          off1_nxt     = (tok_off == OFF_W'(1));
          rd_addr_nxt  = src_addr;
          iss_cnt_nxt  = '0;
          cons_cnt_nxt = '0;
          rd_pend_nxt  = 1'b0;
          if (tok_bad) begin
            state_nxt = ST_ERR;
          end else if (tok_len == '0) begin
            state_nxt = ST_LIT;
          end else begin
            state_nxt = ST_COPY;
          end
        end
      end
      ST_COPY: begin
        if (consume) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = copy_byte;
          out_last_nxt  = 1'b0;
          out_bad_nxt   = 1'b0;
          ram_we        = 1'b1;
          ram_wdata     = copy_byte;
          wp_nxt        = addr_inc(wp_r);
          fill_nxt      = fill_step;
          cons_cnt_nxt  = cons_cnt_r + LEN_W'(1);
          if (cons_cnt_r + LEN_W'(1) == len_r) begin
            state_nxt = ST_LIT;
          end
        end
        if (issue) begin
          ram_re      = 1'b1;
          rd_addr_nxt = addr_inc(rd_addr_r);
          iss_cnt_nxt = iss_cnt_r + LEN_W'(1);
        end
        rd_pend_nxt = issue ? 1'b1 : (consume ? 1'b0 : rd_pend_r);
      end
      ST_LIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = lit_r;
          out_last_nxt  = 1'b1;
          out_bad_nxt   = 1'b0;
          ram_we        = 1'b1;
          ram_wdata     = lit_r;
          wp_nxt        = addr_inc(wp_r);
          fill_nxt      = fill_step;
          state_nxt     = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_bad_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= WINDOW_RESET;
      wp_r        <= '0;
      fill_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_addr_r  <= rd_addr_nxt;
    len_r      <= len_nxt;
    iss_cnt_r  <= iss_cnt_nxt;
    cons_cnt_r <= cons_cnt_nxt;
    lit_r      <= lit_nxt;
    off1_r     <= off1_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  // history RAM: one write port at the write pointer, one registered read port;
  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (ram_we) begin
      hist_mem[wp_r] <= ram_wdata;
    end
    if (ram_re) begin
      ram_q <= hist_mem[rd_addr_r];
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bad_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'(REG_WINDOW)) ? CFG_DATA_W'(window_r) : '0;

endmodule
